// File: hw/rtl/lvm_pkg.sv
// shared widths, types and helpers for the look-at view matrix pipeline
// no dependencies; imported by lvm_bscale, lvm_unit, look_at_view_matrix_unit and the testbench
package lvm_pkg;

   localparam int IN_W     = 32;                  // q16.16 port width
   localparam int FRAC_W   = 16;
   localparam int WIDE_W   = 52;                  // raw vectors before block scaling
   localparam int POS_W    = $clog2(WIDE_W);
   localparam int SC_W     = 25;                  // block scaled component
   localparam int TOP_POS  = 22;                  // leading one lands on this bit
   localparam int XP_W     = 2 * SC_W;            // cross product term
   localparam int MAG_W    = 24;
   localparam int RAD_W    = 64;                  // radicand of the length
   localparam int TRIAL_W  = RAD_W + 2;
   localparam int ROOT_W   = 32;
   localparam int UNIT_SH  = 24;
   localparam int NUM_W    = 48;                  // dividend width
   localparam int DIV_W    = NUM_W + 2;
   localparam int QUO_W    = 18;
   localparam int UNIT_W   = 18;
   localparam int PROD_W   = UNIT_W + IN_W;
   localparam int SUM_W    = PROD_W + 2;

   localparam int BS_LAT    = 3;
   localparam int CROSS_LAT = 2;
   localparam int UNIT_LAT  = 2 + ROOT_W + 1 + QUO_W + 1;
   localparam int DOT_LAT   = 3;

   localparam logic [QUO_W-1:0] Q_ONE    = QUO_W'(65536);
   localparam logic [1:0]       ROW_LAST = 2'd3;

   typedef logic signed [IN_W-1:0]   fix_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [SC_W-1:0]   scaled_type;
   typedef logic signed [UNIT_W-1:0] unit_type;

   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
   } comp_type;

   function automatic logic [POS_W-1:0] lead_pos(input logic [WIDE_W-1:0] w);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < WIDE_W; i++) begin
         if (w[i]) pos = POS_W'(i);
      end
      return pos;
   endfunction

endpackage

// File: hw/rtl/lvm_bscale.sv
// block scaling of a three component vector: common power of two shift so the
// largest magnitude sits in [2^22, 2^23); uses lvm_pkg
module lvm_bscale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lvm_pkg::wide_type   vec_in [3],
   output logic                out_valid,
   output lvm_pkg::scaled_type vec_out [3],
   output logic                out_zero
);
   import lvm_pkg::*;

   logic [BS_LAT-1:0]  valid_ff;
   wide_type           v1_ff [3];
   wide_type           v2_ff [3];
   scaled_type         v3_ff [3];
   logic [WIDE_W-1:0]  or_ff, or_in;
   logic [POS_W-1:0]   amt_ff, amt_in, pos;
   logic               right_ff, zero2_ff, zero3_ff;
   wide_type           neg_v [3];

   // or of magnitudes has the same leading one as the largest magnitude
   always_comb begin
      or_in = '0;
      for (int i = 0; i < 3; i++) begin
         neg_v[i] = -vec_in[i];
         or_in = or_in | (vec_in[i][WIDE_W-1] ? unsigned'(neg_v[i]) : unsigned'(vec_in[i]));
      end
   end

   always_comb begin
      pos = lead_pos(or_ff);
      if (pos > POS_W'(TOP_POS)) amt_in = pos - POS_W'(TOP_POS);
      else amt_in = POS_W'(TOP_POS) - pos;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[BS_LAT-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      v1_ff    <= vec_in;
      or_ff    <= or_in;
      v2_ff    <= v1_ff;
      zero2_ff <= (or_ff == '0);
      right_ff <= pos > POS_W'(TOP_POS);
      amt_ff   <= amt_in;
      zero3_ff <= zero2_ff;
      for (int i = 0; i < 3; i++) begin
         // arithmetic right shift rounds toward minus infinity
         if (right_ff) v3_ff[i] <= SC_W'(v2_ff[i] >>> amt_ff);
         else v3_ff[i] <= SC_W'(v2_ff[i] <<< amt_ff);
      end
   end

   assign out_valid = valid_ff[BS_LAT-1];
   assign vec_out   = v3_ff;
   assign out_zero  = zero3_ff;

endmodule

// File: hw/rtl/lvm_unit.sv
// unit vector of a block scaled axis: pipelined square root, one root bit per
// stage, then pipelined division, one quotient bit per stage; uses lvm_pkg
module lvm_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lvm_pkg::scaled_type vec_in [3],
   output logic                out_valid,
   output lvm_pkg::unit_type   unit_out [3]
);
   import lvm_pkg::*;

   logic [UNIT_LAT-1:0] valid_ff;
   logic signed [XP_W-1:0] sq_w [3];
   scaled_type          neg_v [3];
   logic [NUM_W-1:0]    sq_ff [3];
   comp_type            cmpa_ff, cmpa_in;
   logic [RAD_W-1:0]    rad_sum;

   logic [RAD_W-1:0]    rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]   root_ff [ROOT_W+1];
   comp_type            cmp_ff  [ROOT_W+1];

   logic [NUM_W-1:0]    drem_ff [QUO_W+1][3];
   logic [QUO_W-1:0]    quo_ff  [QUO_W+1][3];
   logic [ROOT_W-1:0]   dd_ff   [QUO_W+1];
   logic [2:0]          dneg_ff [QUO_W+1];
   logic [ROOT_W-1:0]   len;

   unit_type            out_ff [3];
   logic [QUO_W-1:0]    qc [3];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[UNIT_LAT-2:0], in_valid};
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_w[i]        = vec_in[i] * vec_in[i];
         neg_v[i]       = -vec_in[i];
         cmpa_in.neg[i] = vec_in[i][SC_W-1];
         cmpa_in.mag[i] = vec_in[i][SC_W-1] ? neg_v[i][MAG_W-1:0] : vec_in[i][MAG_W-1:0];
      end
      rad_sum = RAD_W'(sq_ff[0]) + RAD_W'(sq_ff[1]) + RAD_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) sq_ff[i] <= sq_w[i][NUM_W-1:0];
      cmpa_ff    <= cmpa_in;
      rem_ff[0]  <= rad_sum << FRAC_W;
      root_ff[0] <= '0;
      cmp_ff[0]  <= cmpa_ff;
   end

   // floor square root, remainder form
   for (genvar s = 0; s < ROOT_W; s++) begin : g_root
      localparam int B = ROOT_W - 1 - s;
      logic [TRIAL_W-1:0] trial, remx;
      assign trial = ({2'b00, RAD_W'(root_ff[s])} << (B + 1)) + (TRIAL_W'(1) << (2 * B));
      assign remx  = {2'b00, rem_ff[s]};
      always_ff @(posedge clock) begin
         if (remx >= trial) begin
            rem_ff[s+1]  <= RAD_W'(remx - trial);
            root_ff[s+1] <= root_ff[s] | (ROOT_W'(1) << B);
         end else begin
            rem_ff[s+1]  <= rem_ff[s];
            root_ff[s+1] <= root_ff[s];
         end
         cmp_ff[s+1] <= cmp_ff[s];
      end
   end

   assign len = root_ff[ROOT_W];

   // dividend rounds to nearest: |c| * 2^24 + floor(len / 2)
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         drem_ff[0][i] <= (NUM_W'(cmp_ff[ROOT_W].mag[i]) << UNIT_SH) + NUM_W'(len >> 1);
         quo_ff[0][i]  <= '0;
      end
      dd_ff[0]   <= len;
      dneg_ff[0] <= cmp_ff[ROOT_W].neg;
   end

   for (genvar t = 0; t < QUO_W; t++) begin : g_div
      localparam int J = QUO_W - 1 - t;
      logic [DIV_W-1:0] dsh;
      logic [DIV_W-1:0] remx [3];
      assign dsh = DIV_W'(dd_ff[t]) << J;
      always_comb begin
         for (int i = 0; i < 3; i++) remx[i] = DIV_W'(drem_ff[t][i]);
      end
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if (remx[i] >= dsh) begin
               drem_ff[t+1][i] <= NUM_W'(remx[i] - dsh);
               quo_ff[t+1][i]  <= quo_ff[t][i] | (QUO_W'(1) << J);
            end else begin
               drem_ff[t+1][i] <= drem_ff[t][i];
               quo_ff[t+1][i]  <= quo_ff[t][i];
            end
         end
         dd_ff[t+1]   <= dd_ff[t];
         dneg_ff[t+1] <= dneg_ff[t];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc[i] = (quo_ff[QUO_W][i] > Q_ONE) ? Q_ONE : quo_ff[QUO_W][i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         out_ff[i] <= dneg_ff[QUO_W][i] ? -unit_type'(qc[i]) : unit_type'(qc[i]);
      end
   end

   assign out_valid = valid_ff[UNIT_LAT-1];
   assign unit_out  = out_ff;

endmodule

// File: hw/rtl/look_at_view_matrix_unit.sv
// left-handed look-at view matrix, q16.16 in and out, four row responses per request
// depends on lvm_pkg, lvm_bscale and lvm_unit
//
//   channel   ports                          handshake
//   request   req_eye_*, req_target_*,       taken when start high and busy low
//             req_up_hint_*
//   response  rsp_row_index, rsp_col0..3,    rsp_valid marks each row,
//             rsp_degenerate, rsp_last_row   no back-pressure
//
// a request is not taken while busy: busy goes high after each accept and stays high
// until the gap counter is back at zero, which is what the four-row response serialiser needs.
// the path from accept to row 0 runs through the 32-stage square root and
// the 18-stage divider; rows 0 to 3 then follow on consecutive cycles.
// reset is synchronous and clears only the valid chain and the control counters.
module look_at_view_matrix_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lvm_pkg::fix_type req_eye_x,
   input  lvm_pkg::fix_type req_eye_y,
   input  lvm_pkg::fix_type req_eye_z,
   input  lvm_pkg::fix_type req_target_x,
   input  lvm_pkg::fix_type req_target_y,
   input  lvm_pkg::fix_type req_target_z,
   input  lvm_pkg::fix_type req_up_hint_x,
   input  lvm_pkg::fix_type req_up_hint_y,
   input  lvm_pkg::fix_type req_up_hint_z,
   output logic             rsp_valid,
   output logic [1:0]       rsp_row_index,
   output lvm_pkg::fix_type rsp_col0,
   output lvm_pkg::fix_type rsp_col1,
   output lvm_pkg::fix_type rsp_col2,
   output lvm_pkg::fix_type rsp_col3,
   output logic             rsp_degenerate,
   output logic             rsp_last_row
);
   import lvm_pkg::*;

   localparam int FS_DLY  = 2 * (CROSS_LAT + BS_LAT);
   localparam int RS_DLY  = CROSS_LAT + BS_LAT;
   localparam int DEG_DLY = UNIT_LAT + DOT_LAT;
   localparam int EYE_DLY = 3 * BS_LAT + 2 * CROSS_LAT + UNIT_LAT;
   localparam logic [1:0] GAP_CYC = 2'd3;
   localparam logic signed [SUM_W:0] HALF    = (SUM_W+1)'(1) <<< (FRAC_W - 1);
   localparam logic signed [SUM_W:0] FIX_MAX = (SUM_W+1)'(32'sh7fffffff);
   localparam logic signed [SUM_W:0] FIX_MIN = -FIX_MAX - (SUM_W+1)'(1);
   localparam fix_type ONE_Q16 = fix_type'(65536);

   logic       accept;
   logic [1:0] gap_ff;

   // front end
   logic     v1_ff;
   fix_type  eye1_ff [3];
   wide_type f1_ff [3], u1_ff [3], f_in [3], u_in [3];

   logic       vf, fz, uz;
   scaled_type fs [3], us [3];

   // right = up x front
   logic [CROSS_LAT-1:0] vr_ff;
   logic signed [XP_W-1:0] ra_w [3], rb_w [3], ra_ff [3], rb_ff [3];
   wide_type rraw_ff [3], rraw_in [3];
   logic       vrs, rz;
   scaled_type rs [3];

   // up = front x right
   logic [CROSS_LAT-1:0] vw_ff;
   logic signed [XP_W-1:0] wa_w [3], wb_w [3], wa_ff [3], wb_ff [3];
   wide_type wraw_ff [3], wraw_in [3];
   logic       vws, wz;
   scaled_type ws [3];

   scaled_type fs_dly_ff [FS_DLY][3];
   scaled_type rs_dly_ff [RS_DLY][3];
   logic [FS_DLY-1:0]  fuz_dly_ff;
   logic [RS_DLY-1:0]  rz_dly_ff;
   logic [DEG_DLY-1:0] deg_dly_ff;
   logic               deg_in;
   fix_type            eye_dly_ff [EYE_DLY][3];

   logic     vu;
   unit_type uf [3], ur [3], uw [3];
   unit_type ax_dly_ff [DOT_LAT][3][3];

   // row 3 dot products
   logic [DOT_LAT-1:0] vd_ff;
   logic signed [PROD_W-1:0] dp_w [3][3], dp_ff [3][3];
   logic signed [SUM_W-1:0]  ds_ff [3];
   logic signed [SUM_W:0]    rt [3], rsh [3];
   fix_type                  dot_in [3], dot_ff [3];

   // response serialiser
   logic       active_ff;
   logic [1:0] row_ff;
   unit_type   ax_ff [3][3];
   fix_type    rdot_ff [3];
   logic       rdeg_ff;

   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else if (accept) begin
         gap_ff <= GAP_CYC;
      end else if (gap_ff != '0) begin
         gap_ff <= gap_ff - 2'd1;
      end
   end

   always_comb begin
      f_in[0] = req_target_x - req_eye_x;
      f_in[1] = req_target_y - req_eye_y;
      f_in[2] = req_target_z - req_eye_z;
      u_in[0] = req_up_hint_x;
      u_in[1] = req_up_hint_y;
      u_in[2] = req_up_hint_z;
   end

   always_ff @(posedge clock) begin
      eye1_ff[0] <= req_eye_x;
      eye1_ff[1] <= req_eye_y;
      eye1_ff[2] <= req_eye_z;
      f1_ff      <= f_in;
      u1_ff      <= u_in;
   end

   lvm_bscale u_bs_front (
      .clock(clock), .reset(reset), .in_valid(v1_ff), .vec_in(f1_ff),
      .out_valid(vf), .vec_out(fs), .out_zero(fz)
   );

   lvm_bscale u_bs_hint (
      .clock(clock), .reset(reset), .in_valid(v1_ff), .vec_in(u1_ff),
      .out_valid(), .vec_out(us), .out_zero(uz)
   );

   always_comb begin
      ra_w[0] = us[1] * fs[2];  rb_w[0] = us[2] * fs[1];
      ra_w[1] = us[2] * fs[0];  rb_w[1] = us[0] * fs[2];
      ra_w[2] = us[0] * fs[1];  rb_w[2] = us[1] * fs[0];
      wa_w[0] = fs_dly_ff[RS_DLY-1][1] * rs[2];  wb_w[0] = fs_dly_ff[RS_DLY-1][2] * rs[1];
      wa_w[1] = fs_dly_ff[RS_DLY-1][2] * rs[0];  wb_w[1] = fs_dly_ff[RS_DLY-1][0] * rs[2];
      wa_w[2] = fs_dly_ff[RS_DLY-1][0] * rs[1];  wb_w[2] = fs_dly_ff[RS_DLY-1][1] * rs[0];
      for (int i = 0; i < 3; i++) begin
         rraw_in[i] = ra_ff[i] - rb_ff[i];
         wraw_in[i] = wa_ff[i] - wb_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      ra_ff   <= ra_w;
      rb_ff   <= rb_w;
      rraw_ff <= rraw_in;
      wa_ff   <= wa_w;
      wb_ff   <= wb_w;
      wraw_ff <= wraw_in;
   end

   lvm_bscale u_bs_right (
      .clock(clock), .reset(reset), .in_valid(vr_ff[CROSS_LAT-1]), .vec_in(rraw_ff),
      .out_valid(vrs), .vec_out(rs), .out_zero(rz)
   );

   lvm_bscale u_bs_up (
      .clock(clock), .reset(reset), .in_valid(vw_ff[CROSS_LAT-1]), .vec_in(wraw_ff),
      .out_valid(vws), .vec_out(ws), .out_zero(wz)
   );

   // side data follows the axes through the fixed-latency stages
   always_ff @(posedge clock) begin
      fs_dly_ff[0]  <= fs;
      rs_dly_ff[0]  <= rs;
      fuz_dly_ff[0] <= fz | uz;
      rz_dly_ff[0]  <= rz;
      deg_dly_ff[0] <= deg_in;
      eye_dly_ff[0] <= eye1_ff;
      ax_dly_ff[0][0] <= ur;
      ax_dly_ff[0][1] <= uw;
      ax_dly_ff[0][2] <= uf;
      for (int k = 1; k < FS_DLY; k++) fs_dly_ff[k] <= fs_dly_ff[k-1];
      for (int k = 1; k < FS_DLY; k++) fuz_dly_ff[k] <= fuz_dly_ff[k-1];
      for (int k = 1; k < RS_DLY; k++) rs_dly_ff[k] <= rs_dly_ff[k-1];
      for (int k = 1; k < RS_DLY; k++) rz_dly_ff[k] <= rz_dly_ff[k-1];
      for (int k = 1; k < DEG_DLY; k++) deg_dly_ff[k] <= deg_dly_ff[k-1];
      for (int k = 1; k < EYE_DLY; k++) eye_dly_ff[k] <= eye_dly_ff[k-1];
      for (int k = 1; k < DOT_LAT; k++) ax_dly_ff[k] <= ax_dly_ff[k-1];
   end

   assign deg_in = fuz_dly_ff[FS_DLY-1] | rz_dly_ff[RS_DLY-1] | wz;

   lvm_unit u_unit_front (
      .clock(clock), .reset(reset), .in_valid(vws), .vec_in(fs_dly_ff[FS_DLY-1]),
      .out_valid(vu), .unit_out(uf)
   );

   lvm_unit u_unit_right (
      .clock(clock), .reset(reset), .in_valid(vws), .vec_in(rs_dly_ff[RS_DLY-1]),
      .out_valid(), .unit_out(ur)
   );

   lvm_unit u_unit_up (
      .clock(clock), .reset(reset), .in_valid(vws), .vec_in(ws),
      .out_valid(), .unit_out(uw)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp_w[0][i] = ur[i] * eye_dly_ff[EYE_DLY-1][i];
         dp_w[1][i] = uw[i] * eye_dly_ff[EYE_DLY-1][i];
         dp_w[2][i] = uf[i] * eye_dly_ff[EYE_DLY-1][i];
      end
      // round half up, then saturate
      for (int a = 0; a < 3; a++) begin
         rt[a]  = HALF - ds_ff[a];
         rsh[a] = rt[a] >>> FRAC_W;
         if (rsh[a] > FIX_MAX) dot_in[a] = FIX_MAX[IN_W-1:0];
         else if (rsh[a] < FIX_MIN) dot_in[a] = FIX_MIN[IN_W-1:0];
         else dot_in[a] = rsh[a][IN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dp_ff <= dp_w;
      for (int a = 0; a < 3; a++) begin
         ds_ff[a] <= SUM_W'(dp_ff[a][0]) + SUM_W'(dp_ff[a][1]) + SUM_W'(dp_ff[a][2]);
      end
      dot_ff <= dot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         vr_ff <= '0;
         vw_ff <= '0;
         vd_ff <= '0;
      end else begin
         v1_ff <= accept;
         vr_ff <= {vr_ff[CROSS_LAT-2:0], vf};
         vw_ff <= {vw_ff[CROSS_LAT-2:0], vrs};
         vd_ff <= {vd_ff[DOT_LAT-2:0], vu};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         row_ff    <= '0;
      end else if (vd_ff[DOT_LAT-1]) begin
         active_ff <= 1'b1;
         row_ff    <= '0;
      end else if (active_ff) begin
         row_ff <= row_ff + 2'd1;
         if (row_ff == ROW_LAST) active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (vd_ff[DOT_LAT-1]) begin
         ax_ff   <= ax_dly_ff[DOT_LAT-1];
         rdot_ff <= dot_ff;
         rdeg_ff <= deg_dly_ff[DEG_DLY-1];
      end
   end

   always_comb begin
      rsp_valid      = active_ff;
      rsp_row_index  = row_ff;
      rsp_degenerate = rdeg_ff;
      rsp_last_row   = (row_ff == ROW_LAST);
      if (rdeg_ff) begin
         rsp_col0 = '0;
         rsp_col1 = '0;
         rsp_col2 = '0;
         rsp_col3 = '0;
      end else if (row_ff == ROW_LAST) begin
         rsp_col0 = rdot_ff[0];
         rsp_col1 = rdot_ff[1];
         rsp_col2 = rdot_ff[2];
         rsp_col3 = ONE_Q16;
      end else begin
         rsp_col0 = IN_W'(ax_ff[0][row_ff]);
         rsp_col1 = IN_W'(ax_ff[1][row_ff]);
         rsp_col2 = IN_W'(ax_ff[2][row_ff]);
         rsp_col3 = '0;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken without busy following");

   a_rows_in_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_index != ROW_LAST |=>
         rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1)
      else $error("response rows not consecutive");

   a_deg_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_index != ROW_LAST |=> $stable(rsp_degenerate))
      else $error("degenerate flag changed within a matrix");

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_col3 == '0 && rsp_col0 == '0)
      else $error("degenerate response carries non-zero entries");

endmodule

// File: bench/look_at_view_matrix_unit_tb.sv
// testbench for look_at_view_matrix_unit: directed and random camera requests, scoreboarded
// depends on lvm_pkg and look_at_view_matrix_unit
module look_at_view_matrix_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lvm_pkg::*;

   typedef struct {
      logic [1:0] row_index;
      fix_type    col [4];
      logic       degenerate;
      logic       last_row;
   } row_type;

   class view_matrix_board;
      row_type expected_rows [$];
      int      errors;
      int      rows_checked;
      int      degenerate_rows;

      function void block_scale(inout longint v [3]);
         longint m;
         int     k;
         m = 0;
         k = 0;
         for (int i = 0; i < 3; i++) begin
            if ((v[i] < 0 ? -v[i] : v[i]) > m) m = v[i] < 0 ? -v[i] : v[i];
         end
         if (m == 0) return;
         if (m >= (64'sd1 <<< 23)) begin
            while (m >= (64'sd1 <<< 23)) begin
               m = m >>> 1;
               k++;
            end
            for (int i = 0; i < 3; i++) v[i] = v[i] >>> k;
         end else begin
            while (m < (64'sd1 <<< 22)) begin
               m = m <<< 1;
               k++;
            end
            for (int i = 0; i < 3; i++) v[i] = v[i] <<< k;
         end
      endfunction

      function void cross_product(output longint o [3], input longint a [3],
                                  input longint b [3]);
         o[0] = a[1] * b[2] - a[2] * b[1];
         o[1] = a[2] * b[0] - a[0] * b[2];
         o[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned res, bitval;
         res = 0;
         bitval = 64'd1 << 62;
         while (bitval > x) bitval = bitval >> 2;
         while (bitval != 0) begin
            if (x >= res + bitval) begin
               x = x - (res + bitval);
               res = (res >> 1) + bitval;
            end else begin
               res = res >> 1;
            end
            bitval = bitval >> 2;
         end
         return res;
      endfunction

      function void normalise(inout longint v [3]);
         longint unsigned len2, len, a, q;
         len2 = 0;
         for (int i = 0; i < 3; i++) len2 += longint'(v[i] * v[i]);
         len = int_sqrt(len2 << 16);
         if (len == 0) len = 1;
         for (int i = 0; i < 3; i++) begin
            a = v[i] < 0 ? -v[i] : v[i];
            q = ((a << 24) + (len >> 1)) / len;
            if (q > 65536) q = 65536;
            v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
         end
      endfunction

      function fix_type eye_offset(longint a [3], longint e [3]);
         longint s, r;
         s = a[0] * e[0] + a[1] * e[1] + a[2] * e[2];
         r = (-s + 32768) >>> 16;
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return fix_type'(r);
      endfunction

      // works out the four matrix rows that one accepted request must produce
      function void note_request(fix_type eye [3], fix_type target [3], fix_type hint [3]);
         longint  e [3], f [3], u [3], r [3], w [3];
         bit      deg;
         row_type row;
         for (int i = 0; i < 3; i++) begin
            e[i] = longint'(eye[i]);
            f[i] = longint'(target[i]) - e[i];
            u[i] = longint'(hint[i]);
         end
         block_scale(f);
         block_scale(u);
         cross_product(r, u, f);
         block_scale(r);
         cross_product(w, f, r);
         block_scale(w);
         deg = (f[0] == 0 && f[1] == 0 && f[2] == 0) || (r[0] == 0 && r[1] == 0 && r[2] == 0)
               || (w[0] == 0 && w[1] == 0 && w[2] == 0);
         if (!deg) begin
            normalise(f);
            normalise(r);
            normalise(w);
         end
         for (int i = 0; i < 4; i++) begin
            row.row_index = 2'(i);
            row.degenerate = deg;
            row.last_row = (i == 3);
            if (deg) begin
               for (int j = 0; j < 4; j++) row.col[j] = '0;
            end else if (i < 3) begin
               row.col[0] = fix_type'(r[i]);
               row.col[1] = fix_type'(w[i]);
               row.col[2] = fix_type'(f[i]);
               row.col[3] = '0;
            end else begin
               row.col[0] = eye_offset(r, e);
               row.col[1] = eye_offset(w, e);
               row.col[2] = eye_offset(f, e);
               row.col[3] = 32'sd65536;
            end
            expected_rows.push_back(row);
         end
      endfunction

      function void check_row(row_type got);
         row_type want;
         if (expected_rows.size() == 0) begin
            $error("row %0d arrived with no request outstanding", got.row_index);
            errors++;
            return;
         end
         want = expected_rows.pop_front();
         rows_checked++;
         if (want.degenerate) degenerate_rows++;
         if (got.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
            errors++;
         end
         for (int j = 0; j < 4; j++) begin
            if (got.col[j] !== want.col[j]) begin
               $error("col%0d: expected %0d, got %0d", j, want.col[j], got.col[j]);
               errors++;
            end
         end
         if (got.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
            errors++;
         end
         if (got.last_row !== want.last_row) begin
            $error("last_row: expected %0b, got %0b", want.last_row, got.last_row);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   fix_type req_eye_x, req_eye_y, req_eye_z;
   fix_type req_target_x, req_target_y, req_target_z;
   fix_type req_up_hint_x, req_up_hint_y, req_up_hint_z;
   logic       rsp_valid;
   logic [1:0] rsp_row_index;
   fix_type    rsp_col0, rsp_col1, rsp_col2, rsp_col3;
   logic       rsp_degenerate;
   logic       rsp_last_row;

   view_matrix_board board;
   int requests_sent;

   look_at_view_matrix_unit DUT (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("look_at_view_matrix_unit_tb: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      row_type got;
      if (!reset && rsp_valid) begin
         got.row_index = rsp_row_index;
         got.col[0] = rsp_col0;
         got.col[1] = rsp_col1;
         got.col[2] = rsp_col2;
         got.col[3] = rsp_col3;
         got.degenerate = rsp_degenerate;
         got.last_row = rsp_last_row;
         board.check_row(got);
      end
   end

   task automatic send_request(fix_type eye [3], fix_type target [3], fix_type hint [3]);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      {req_eye_x, req_eye_y, req_eye_z} <= {eye[0], eye[1], eye[2]};
      {req_target_x, req_target_y, req_target_z} <= {target[0], target[1], target[2]};
      {req_up_hint_x, req_up_hint_y, req_up_hint_z} <= {hint[0], hint[1], hint[2]};
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(eye, target, hint);
      requests_sent++;
   endtask

   function automatic fix_type any_value();
      case ($urandom_range(0, 5))
         0: return fix_type'($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
         1: return fix_type'($urandom_range(0, 2000)) - 32'sd1000;
         2, 3: return fix_type'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
         default: return fix_type'($urandom);
      endcase
   endfunction

   task automatic send_directed();
      fix_type e [3], t [3], h [3];
      // eye on target, zero up hint, hint along the view, plus extremes, then eight random requests
      e = '{32'sd0, 32'sd0, -32'sd327680}; t = '{32'sd0, 32'sd0, 32'sd0};
      h = '{32'sd0, 32'sd65536, 32'sd0};
      send_request(e, t, h);
      send_request(e, e, h);
      send_request(e, t, '{32'sd0, 32'sd0, 32'sd0});
      send_request(e, t, '{32'sd0, 32'sd0, 32'sd131072});
      send_request(e, t, '{32'sd0, 32'sd0, -32'sd1});
      send_request('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
                   '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, h);
      send_request('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
                   '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff},
                   '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000});
      send_request('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff}, t,
                   '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000});
      send_request('{32'sd1, 32'sd0, 32'sd0}, t, '{32'sd0, 32'sd1, 32'sd0});
      send_request('{32'sd0, 32'sd0, 32'sd1}, t, '{32'sd1, 32'sd0, 32'sd0});
      send_request('{32'sd655360, 32'sd327680, -32'sd655360},
                   '{32'sd65536, 32'sd0, 32'sd65536}, '{32'sd0, 32'sd65536, 32'sd0});
      send_request('{32'sh7000_0000, -32'sh7000_0000, 32'sh7000_0000},
                   '{-32'sh7000_0000, 32'sh7000_0000, -32'sh7000_0000},
                   '{32'sd0, 32'sd65536, 32'sd1});
      for (int i = 0; i < 8; i++) begin
         e = '{any_value(), any_value(), any_value()};
         t = '{any_value(), any_value(), any_value()};
         h = '{any_value(), any_value(), any_value()};
         send_request(e, t, h);
      end
   endtask

   initial begin
      fix_type e [3], t [3], h [3];
      int      wait_cycles;
      board = new();
      reset = 1'b1;
      start = 1'b0;
      {req_eye_x, req_eye_y, req_eye_z} = '0;
      {req_target_x, req_target_y, req_target_z} = '0;
      {req_up_hint_x, req_up_hint_y, req_up_hint_z} = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      for (int n = 0; n < 200; n++) begin
         if (n == 100) begin
            start <= 1'b0;
            while (board.expected_rows.size() != 0) @(posedge clock);
         end
         e = '{any_value(), any_value(), any_value()};
         t = '{any_value(), any_value(), any_value()};
         h = '{any_value(), any_value(), any_value()};
         case ($urandom_range(0, 9))
            0: t = e;
            1: h = '{t[0] - e[0], t[1] - e[1], t[2] - e[2]};
            2: h = '{32'sd0, 32'sd0, 32'sd0};
            default: ;
         endcase
         send_request(e, t, h);
      end
      start <= 1'b0;
      wait_cycles = 0;
      while (board.expected_rows.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (80) @(posedge clock);
      $display("%0d requests sent, %0d rows checked, %0d of them degenerate",
               requests_sent, board.rows_checked, board.degenerate_rows);
      if (board.expected_rows.size() != 0) begin
         $error("%0d rows never arrived", board.expected_rows.size());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("look_at_view_matrix_unit_tb: PASS");
      end else begin
         $display("look_at_view_matrix_unit_tb: FAIL");
      end
      $finish;
   end
endmodule

// File: sim.f
hw/rtl/lvm_pkg.sv
hw/rtl/lvm_bscale.sv
hw/rtl/lvm_unit.sv
hw/rtl/look_at_view_matrix_unit.sv
bench/look_at_view_matrix_unit_tb.sv
